@@ design/sensor_reading_decoder_core_macros.svh @@
// -----------------------------------------------------------------------------
// Sensor reading decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef SENSOR_READING_DECODER_CORE_MACROS_SVH
`define SENSOR_READING_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define SRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/srd_pkg.sv @@
// -----------------------------------------------------------------------------
// Sensor reading decoder package
// Shared widths, register indexes, mode and operation codes, item type and
// small constant tables.
// -----------------------------------------------------------------------------
package srd_pkg;

  localparam int unsigned PortCount  = 4;
  localparam int unsigned MaxPorts   = 4;
  localparam int unsigned PortW      = $clog2(MaxPorts);
  localparam int unsigned ModeW      = 5;
  localparam int unsigned ChanW      = 2;
  localparam int unsigned RawW       = 64;
  localparam int unsigned ReadW      = 16;
  localparam int unsigned DataW      = 16;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 5;

  localparam int unsigned RegModeBase = 0;
  localparam int unsigned RegChanBase = 4;
  localparam int unsigned RegCount    = 8;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam int unsigned MulW       = 16;
  localparam int unsigned ProdW      = 28;
  localparam int unsigned TMagW      = 11;
  localparam int unsigned TM9W       = 14;
  localparam int unsigned FProdW     = 30;

  localparam logic [MulW-1:0] Div10Mul   = 16'd52429;
  localparam int unsigned     Div10Shift = 19;
  localparam logic [MulW-1:0] Div41Mul   = 16'd6394;
  localparam int unsigned     Div41Shift = 18;
  localparam logic [MulW-1:0] Div5Mul    = 16'd52429;
  localparam int unsigned     Div5Shift  = 18;

  localparam logic [ReadW-1:0] FahrOffset = 16'd320;
  localparam logic [ReadW-1:0] SoundFull  = 16'd100;
  localparam logic [7:0]       TouchPressed = 8'd13;

  typedef enum logic [ModeW-1:0] {
    ModeNone       = 5'd0,
    ModeTouchPress = 5'd1,
    ModeTouchBump  = 5'd2,
    ModeColReflect = 5'd3,
    ModeColAmbient = 5'd4,
    ModeColColor   = 5'd5,
    ModeUsCm       = 5'd6,
    ModeUsMm       = 5'd7,
    ModeUsInch     = 5'd8,
    ModeGyroAngle  = 5'd9,
    ModeGyroRate   = 5'd10,
    ModeIrProx     = 5'd11,
    ModeIrSeek     = 5'd12,
    ModeIrRemote   = 5'd13,
    ModeIrSeeker   = 5'd14,
    ModeTempC      = 5'd15,
    ModeTempF      = 5'd16,
    ModeSoundDb    = 5'd17,
    ModeSoundDba   = 5'd18,
    ModeOldTouch   = 5'd19,
    ModeOldLight   = 5'd20
  } sensor_mode_e;

  typedef enum logic [3:0] {
    OpNone,
    OpTouchPress,
    OpSample,
    OpTouchDiv,
    OpByte,
    OpNibble,
    OpUsCm,
    OpUsMm,
    OpGyro,
    OpIrSeek,
    OpIrRemote,
    OpTempC,
    OpTempF,
    OpSound
  } decode_op_e;

  typedef struct packed {
    decode_op_e       op;
    logic [DataW-1:0] data;
  } srd_item_t;

  function automatic logic [3:0] tenth_frac(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd0;
      4'd2:    r = 4'd1;
      4'd3:    r = 4'd2;
      4'd4:    r = 4'd2;
      4'd5:    r = 4'd3;
      4'd6:    r = 4'd4;
      4'd7:    r = 4'd4;
      4'd8:    r = 4'd5;
      4'd9:    r = 4'd6;
      4'd10:   r = 4'd6;
      4'd11:   r = 4'd7;
      4'd12:   r = 4'd8;
      4'd13:   r = 4'd8;
      4'd14:   r = 4'd9;
      default: r = 4'd10;
    endcase
    return r;
  endfunction

endpackage

@@ design/srd_front.sv @@
// -----------------------------------------------------------------------------
// Sensor reading decoder front end
// Holds the per-port configuration, accepts items and turns each into a
// decode operation with its operand bits.
// -----------------------------------------------------------------------------
module srd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           queue_full_i,
  input  logic [srd_pkg::PortW-1:0]      sensor_port_i,
  input  logic [srd_pkg::RawW-1:0]       raw_word_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [srd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [srd_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                           push_o,
  output srd_pkg::srd_item_t             item_o
);
  import srd_pkg::*;

  sensor_mode_e     mode_q [MaxPorts];
  sensor_mode_e     mode_d [MaxPorts];
  logic [ChanW-1:0] chan_q [MaxPorts];
  logic [ChanW-1:0] chan_d [MaxPorts];
  logic             cfg_wr;
  sensor_mode_e     mode;
  logic [ChanW-1:0] chan;
  logic             absent;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign push_o      = start && !queue_full_i;

  always_comb begin
    mode_d = mode_q;
    chan_d = chan_q;
    if (cfg_wr) begin
      if (cfg_index_i < CfgIdxW'(RegChanBase)) begin
        mode_d[cfg_index_i[PortW-1:0]] = sensor_mode_e'(cfg_data_i[ModeW-1:0]);
      end else if (cfg_index_i < CfgIdxW'(RegCount)) begin
        chan_d[cfg_index_i[PortW-1:0]] = cfg_data_i[ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '{default: ModeNone};
      chan_q <= '{default: '0};
    end else begin
      mode_q <= mode_d;
      chan_q <= chan_d;
    end
  end

  assign mode   = mode_q[sensor_port_i];
  assign chan   = chan_q[sensor_port_i];
  assign absent = {1'b0, sensor_port_i} >= (PortW + 1)'(PortCount);

  always_comb begin
    item_o.data = raw_word_i[DataW-1:0];
    case (mode)
      ModeTouchPress:                         item_o.op = OpTouchPress;
      ModeTouchBump, ModeOldLight:            item_o.op = OpSample;
      ModeOldTouch:                           item_o.op = OpTouchDiv;
      ModeColReflect, ModeColAmbient, ModeIrProx: item_o.op = OpByte;
      ModeColColor, ModeIrSeeker:             item_o.op = OpNibble;
      ModeUsCm:                               item_o.op = OpUsCm;
      ModeUsMm, ModeUsInch:                   item_o.op = OpUsMm;
      ModeGyroAngle, ModeGyroRate:            item_o.op = OpGyro;
      ModeIrSeek: begin
        item_o.op   = OpIrSeek;
        item_o.data = {8'h00, raw_word_i[{chan, 4'b0000} +: 8]};
      end
      ModeIrRemote: begin
        item_o.op   = OpIrRemote;
        item_o.data = {8'h00, raw_word_i[{chan, 3'b000} +: 8]};
      end
      ModeTempC: begin
        item_o.op   = OpTempC;
        item_o.data = {4'h0, raw_word_i[15:4]};
      end
      ModeTempF: begin
        item_o.op   = OpTempF;
        item_o.data = {4'h0, raw_word_i[15:4]};
      end
      ModeSoundDb, ModeSoundDba:              item_o.op = OpSound;
      default:                                item_o.op = OpNone;
    endcase
    if (absent) begin
      item_o.op = OpNone;
    end
  end

endmodule

@@ design/srd_queue.sv @@
// -----------------------------------------------------------------------------
// Sensor reading decoder item queue
// Short FIFO between the front end and the decode pipeline.
// -----------------------------------------------------------------------------
`include "sensor_reading_decoder_core_macros.svh"

module srd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  srd_pkg::srd_item_t  item_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                head_valid_o,
  output srd_pkg::srd_item_t  head_o
);
  import srd_pkg::*;

  srd_item_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign full_o       = count_q == QCntW'(QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = push_i && !full_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `SRD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= QCntW'(QueueDepth), "queue count above depth")
  `SRD_ASSERT_NXT(a_count_inc, push && !pop, count_q == QCntW'($past(count_q) + 1'b1), "count did not rise")
  `SRD_ASSERT_NXT(a_count_dec, pop && !push, count_q == QCntW'($past(count_q) - 1'b1), "count did not fall")

endmodule

@@ design/srd_back.sv @@
// -----------------------------------------------------------------------------
// Sensor reading decoder back end
// Two-stage decode pipeline: operand products in the first stage, final
// scaling and sign handling into the output register in the second.
// -----------------------------------------------------------------------------
`include "sensor_reading_decoder_core_macros.svh"

module srd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  srd_pkg::srd_item_t                head_i,
  output logic                              pop_o,
  output logic                              reading_valid_o,
  output logic signed [srd_pkg::ReadW-1:0]  reading_o
);
  import srd_pkg::*;

  logic [DataW-1:0]  u;
  logic [7:0]        tdiv_d;
  logic [MulW-1:0]   mul_k;
  logic [ProdW-1:0]  prod_d;
  logic [11:0]       tmag12;
  logic              neg_d;
  logic [TMagW-1:0]  tmag_d;
  logic [TM9W-1:0]   tm9_d;

  logic              s1_valid_q;
  decode_op_e        s1_op_q;
  logic [DataW-1:0]  s1_data_q;
  logic [7:0]        s1_tdiv_q;
  logic [ProdW-1:0]  s1_prod_q;
  logic              s1_neg_q;
  logic [TMagW-1:0]  s1_tmag_q;
  logic [TM9W-1:0]   s1_tm9_q;

  logic [FProdW-1:0] fprod;
  logic [ReadW-1:0]  fmag;
  logic [ReadW-1:0]  reading_d;
  logic [ReadW-1:0]  reading_q;
  logic              valid_q;

  assign pop_o = head_valid_i;
  assign u     = head_i.data;

  always_comb begin
    tdiv_d = u[15:8] + {7'b0, u[15] && (u[7:0] != 8'h00)};
    mul_k  = (head_i.op == OpSound) ? Div41Mul : Div10Mul;
    prod_d = ProdW'(u[11:0]) * ProdW'(mul_k);
    neg_d  = u[11];
    tmag12 = neg_d ? 12'({1'b0, u[10:0] ^ 11'h7FF} + 12'd1) : u[11:0];
    tmag_d = TMagW'(TMagW'(tmag12[11:4]) * TMagW'(10)) + TMagW'(tenth_frac(tmag12[3:0]));
    tm9_d  = TM9W'({tmag_d, 3'b000}) + TM9W'(tmag_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= head_valid_i;
      valid_q    <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q   <= head_i.op;
    s1_data_q <= u;
    s1_tdiv_q <= tdiv_d;
    s1_prod_q <= prod_d;
    s1_neg_q  <= neg_d;
    s1_tmag_q <= tmag_d;
    s1_tm9_q  <= tm9_d;
    reading_q <= reading_d;
  end

  assign fprod = FProdW'(s1_tm9_q) * FProdW'(Div5Mul);
  assign fmag  = ReadW'(fprod >> Div5Shift);

  always_comb begin
    case (s1_op_q)
      OpTouchPress: begin
        if (s1_tdiv_q == 8'h00) begin
          reading_d = '0;
        end else if (s1_tdiv_q == TouchPressed) begin
          reading_d = ReadW'(1);
        end else begin
          reading_d = '1;
        end
      end
      OpSample:   reading_d = s1_data_q;
      OpTouchDiv: reading_d = {{8{s1_tdiv_q[7]}}, s1_tdiv_q};
      OpByte:     reading_d = {8'h00, s1_data_q[7:0]};
      OpNibble:   reading_d = {12'h000, s1_data_q[3:0]};
      OpUsCm:     reading_d = ReadW'(s1_prod_q >> Div10Shift);
      OpUsMm:     reading_d = {4'h0, s1_data_q[11:0]};
      OpGyro: begin
        reading_d = s1_data_q[15] ? {1'b0, s1_data_q[14:0]} - 16'h7FFF : s1_data_q;
      end
      OpIrSeek: begin
        reading_d = s1_data_q[7] ? {9'h000, s1_data_q[6:0]} - 16'h007F
                                 : {8'h00, s1_data_q[7:0]};
      end
      OpIrRemote: reading_d = {8'h00, s1_data_q[7:0]};
      OpTempC: begin
        reading_d = s1_neg_q ? ReadW'(0) - ReadW'(s1_tmag_q) : ReadW'(s1_tmag_q);
      end
      OpTempF: begin
        reading_d = s1_neg_q ? FahrOffset - fmag : FahrOffset + fmag;
      end
      OpSound:    reading_d = SoundFull - ReadW'(s1_prod_q >> Div41Shift);
      default:    reading_d = '1;
    endcase
  end

  assign reading_valid_o = valid_q;
  assign reading_o       = reading_q;

  `SRD_ASSERT_NXT(a_valid_follows, s1_valid_q, reading_valid_o, "decoded item lost")
  `SRD_ASSERT_NXT(a_no_spurious, !s1_valid_q, !reading_valid_o, "result without item")
  `SRD_ASSERT_NXT(a_none_minus_one, s1_valid_q && s1_op_q == OpNone, reading_o == {ReadW{1'b1}}, "no-sensor item not -1")

endmodule

@@ design/sensor_reading_decoder_core.sv @@
// -----------------------------------------------------------------------------
// Sensor reading decoder core
// Decodes one raw sensor word per item into a signed reading, using the
// configured mode and beacon channel of the item's port.
// -----------------------------------------------------------------------------
// Usage:
//   An item (sensor_port_i, raw_word_i) is taken at a rising edge with start
//   high and busy low. Every item gives exactly one result, shown on
//   reading_o for one cycle with reading_valid_o high; results leave in the
//   order items came in.
//   The item passes through the queue entry, the first-stage registers and
//   the output register. Throughput: one item per cycle, sustained; busy
//   only rises if the two-entry queue is full, which the one-item-per-cycle
//   decode pipeline never lets happen.
//   The receiver cannot stall; the pipeline drains one item every cycle.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
//   Indexes 0 to 3 are the port modes, 4 to 7 the beacon channels; other
//   indexes are ignored. cfg_ready_o is always high. Write only while idle.
//   Reset clears all modes to none and channels to zero and empties the
//   pipeline; no clearing pass is needed.
// -----------------------------------------------------------------------------
module sensor_reading_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [srd_pkg::PortW-1:0]         sensor_port_i,
  input  logic [srd_pkg::RawW-1:0]          raw_word_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [srd_pkg::CfgDataW-1:0]      cfg_data_i,
  output logic                              reading_valid_o,
  output logic signed [srd_pkg::ReadW-1:0]  reading_o
);
  import srd_pkg::*;

  logic      push;
  srd_item_t item;
  logic      full;
  logic      head_valid;
  srd_item_t head;
  logic      pop;

  assign busy = full;

  srd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .queue_full_i  (full),
    .sensor_port_i (sensor_port_i),
    .raw_word_i    (raw_word_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_o        (push),
    .item_o        (item)
  );

  srd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  srd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .reading_valid_o (reading_valid_o),
    .reading_o       (reading_o)
  );

endmodule

@@ sim/tb_sensor_reading_decoder_core.sv @@
// -----------------------------------------------------------------------------
// Sensor reading decoder core testbench
// Drives raw sensor words through every port under many mode and channel
// settings, predicts each decoded reading and compares it in arrival order.
// -----------------------------------------------------------------------------
module tb_sensor_reading_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import srd_pkg::*;

  class reading_ledger;
    logic [ModeW-1:0] port_mode [PortCount];
    logic [ChanW-1:0] port_chan [PortCount];
    logic signed [ReadW-1:0] expected_readings [$];
    int unsigned mismatches;

    function new();
      foreach (port_mode[i]) begin
        port_mode[i] = '0;
        port_chan[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void apply_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx < RegChanBase) begin
        port_mode[idx - RegModeBase] = data[ModeW-1:0];
      end else if (idx < RegCount) begin
        port_chan[idx - RegChanBase] = data[ChanW-1:0];
      end
    endfunction

    function logic signed [ReadW-1:0] decode_reading(logic [ModeW-1:0] mode,
                                                     logic [ChanW-1:0] ch,
                                                     logic [RawW-1:0] raw);
      int u;
      int s;
      int h;
      int t;
      int r;
      bit neg;
      u = int'(raw[15:0]);
      s = int'($signed(raw[15:0]));
      r = -1;
      case (mode)
        ModeTouchPress: begin
          h = s / 256;
          if (h == 0) begin
            r = 0;
          end else if (h == int'(TouchPressed)) begin
            r = 1;
          end
        end
        ModeTouchBump, ModeOldLight: r = s;
        ModeOldTouch: r = s / 256;
        ModeColReflect, ModeColAmbient, ModeIrProx: r = u & 32'sh00FF;
        ModeColColor, ModeIrSeeker: r = u & 32'sh000F;
        ModeUsCm: r = (u & 32'sh0FFF) / 10;
        ModeUsMm, ModeUsInch: r = u & 32'sh0FFF;
        ModeGyroAngle, ModeGyroRate: begin
          r = u;
          if (u[15]) begin
            r = (u & 32'sh7FFF) - 32'sh7FFF;
          end
        end
        ModeIrSeek: begin
          h = int'(raw[16*ch +: 8]);
          r = h;
          if (h[7]) begin
            r = (h & 32'sh7F) - 32'sh7F;
          end
        end
        ModeIrRemote: r = int'(raw[8*ch +: 8]);
        ModeTempC, ModeTempF: begin
          h = int'(raw[15:4]);
          neg = h[11];
          if (neg) begin
            h = ((h & 32'sh7FF) ^ 32'sh7FF) + 1;
          end
          t = ((h >>> 4) & 32'sh00FF) * 10 + ((h & 32'sh000F) * 10) / 15;
          if (neg) begin
            t = -t;
          end
          if (mode == ModeTempF) begin
            t = (t * 9) / 5 + 320;
          end
          r = t;
        end
        ModeSoundDb, ModeSoundDba: r = 100 - ((u & 32'sh0FFF) * 100) / 4100;
        default: r = -1;
      endcase
      return r[ReadW-1:0];
    endfunction

    function void note_item(logic [PortW-1:0] port, logic [RawW-1:0] raw);
      if (port >= PortCount) begin
        expected_readings.push_back(-16'sd1);
      end else begin
        expected_readings.push_back(decode_reading(port_mode[port], port_chan[port], raw));
      end
    endfunction

    function void check_reading(logic signed [ReadW-1:0] got);
      logic signed [ReadW-1:0] want;
      if (expected_readings.size() == 0) begin
        mismatches++;
        $display("%0t: reading with none expected, expected none actual %0d", $time, got);
      end else begin
        want = expected_readings.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: reading mismatch, expected %0d actual %0d", $time, want, got);
        end
      end
    endfunction

    function int outstanding();
      return expected_readings.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (expected_readings.size() == 0);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [PortW-1:0]        sensor_port_i;
  logic [RawW-1:0]         raw_word_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [CfgDataW-1:0]     cfg_data_i;
  logic                    reading_valid_o;
  logic signed [ReadW-1:0] reading_o;

  reading_ledger ledger = new();
  bit            sender_idles;
  logic [PortW-1:0] probe_port;

  sensor_reading_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sensor_port_i   (sensor_port_i),
    .raw_word_i      (raw_word_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .reading_valid_o (reading_valid_o),
    .reading_o       (reading_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        ledger.apply_write(cfg_index_i, cfg_data_i);
      end
      if (start && !busy) begin
        ledger.note_item(sensor_port_i, raw_word_i);
      end
      if (reading_valid_o) begin
        ledger.check_reading(reading_o);
      end
    end
  end

  task automatic send_item(logic [PortW-1:0] port, logic [RawW-1:0] raw);
    int gap;
    gap = sender_idles ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    sensor_port_i <= port;
    raw_word_i    <= raw;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic close_writes();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    start <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (ledger.outstanding() > 0 && guard < 64);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic probe_mode(logic [ModeW-1:0] mode, logic [ChanW-1:0] ch,
                            logic [RawW-1:0] raw);
    logic [PortW-1:0] port;
    port = probe_port;
    probe_port = probe_port + 1'b1;
    wait_drained();
    write_reg(CfgIdxW'(RegModeBase + port), mode);
    write_reg(CfgIdxW'(RegChanBase + port), {3'($urandom_range(0, 7)), ch});
    write_reg(CfgIdxW'(RegCount + $urandom_range(0, 7)), CfgDataW'($urandom));
    close_writes();
    send_item(port, raw);
  endtask

  function automatic logic [ModeW-1:0] random_mode();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      return ModeNone;
    end else if (k == 1) begin
      return ModeW'($urandom_range(21, 31));
    end
    return ModeW'($urandom_range(1, 20));
  endfunction

  function automatic logic [RawW-1:0] random_raw();
    logic [RawW-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r[15:8] = 8'h0D;
      1: r[15:8] = 8'h00;
      2: r[15:8] = 8'hF3;
      3: begin
        case ($urandom_range(0, 3))
          0: r[15:0] = 16'h8000;
          1: r[15:0] = 16'h7FFF;
          2: r[15:0] = 16'hFFFF;
          default: r[15:0] = 16'h0000;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic program_phase(int phase);
    logic [CfgDataW-1:0] data;
    wait_drained();
    for (int i = 0; i < PortCount; i++) begin
      if (phase == 0) begin
        data = ModeOldLight;
      end else if (phase == 1) begin
        data = '1;
      end else begin
        data = random_mode();
      end
      write_reg(CfgIdxW'(RegModeBase + i), data);
    end
    for (int i = 0; i < PortCount; i++) begin
      if (phase == 0) begin
        data = 5'd3;
      end else if (phase == 1) begin
        data = '1;
      end else if (phase == 2) begin
        data = '0;
      end else begin
        data = CfgDataW'($urandom);
      end
      write_reg(CfgIdxW'(RegChanBase + i), data);
    end
    write_reg(CfgIdxW'(RegCount + $urandom_range(0, 7)), CfgDataW'($urandom));
    close_writes();
  endtask

  initial begin
    start         = 1'b0;
    sensor_port_i = '0;
    raw_word_i    = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    sender_idles  = 1'b1;
    probe_port    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With reset settings every port has no sensor.
    repeat (3) send_item(PortW'($urandom_range(0, 3)), {$urandom, $urandom});

    probe_mode(ModeNone,       2'd0, '1);
    probe_mode(ModeTouchPress, 2'd1, 64'h0000_0000_0000_0D00);
    probe_mode(ModeTouchPress, 2'd2, 64'hFFFF_FFFF_FFFF_FF01);
    probe_mode(ModeTouchBump,  2'd3, 64'h0000_0000_0000_8000);
    probe_mode(ModeOldLight,   2'd0, 64'hFFFF_FFFF_FFFF_7FFF);
    probe_mode(ModeOldTouch,   2'd1, 64'h0000_0000_0000_80FF);
    probe_mode(ModeColReflect, 2'd2, '1);
    probe_mode(ModeColAmbient, 2'd3, 64'h0000_0000_0000_12AB);
    probe_mode(ModeColColor,   2'd0, 64'h0000_0000_0000_FFFF);
    probe_mode(ModeUsCm,       2'd1, 64'h0000_0000_0000_0FFF);
    probe_mode(ModeUsMm,       2'd2, 64'h0000_0000_0000_FFFF);
    probe_mode(ModeUsInch,     2'd3, 64'h0000_0000_0000_0ABC);
    probe_mode(ModeGyroAngle,  2'd0, 64'h0000_0000_0000_8000);
    probe_mode(ModeGyroRate,   2'd1, 64'h0000_0000_0000_7FFF);
    probe_mode(ModeIrProx,     2'd2, '1);
    probe_mode(ModeIrSeek,     2'd3, 64'h0080_0000_0000_0000);
    probe_mode(ModeIrSeek,     2'd0, 64'hFFFF_FFFF_FFFF_FF7F);
    probe_mode(ModeIrRemote,   2'd3, 64'h0000_0000_A500_0000);
    probe_mode(ModeIrSeeker,   2'd1, 64'h0000_0000_0000_FFFF);
    probe_mode(ModeTempC,      2'd2, 64'h0000_0000_0000_8000);
    probe_mode(ModeTempF,      2'd3, 64'h0000_0000_0000_7FF0);
    probe_mode(ModeTempF,      2'd0, '1);
    probe_mode(ModeSoundDb,    2'd1, 64'h0000_0000_0000_0FFF);
    probe_mode(ModeSoundDba,   2'd2, '0);
    probe_mode(5'd31,          2'd3, 64'h0000_0000_0000_1234);

    for (int phase = 0; phase < 25; phase++) begin
      program_phase(phase);
      sender_idles = (phase % 4 != 3);
      for (int n = 0; n < 50; n++) begin
        send_item(PortW'($urandom_range(0, 3)), random_raw());
      end
    end

    wait_drained();
    if (ledger.clean()) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/srd_pkg.sv
design/srd_front.sv
design/srd_queue.sv
design/srd_back.sv
design/sensor_reading_decoder_core.sv
sim/tb_sensor_reading_decoder_core.sv
